FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// types, register map and constants of the collision and rollover detector
// ----------------------------------------------------------------------------
package crd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [2:0] {
        REG_ACCEL_THR = 3'd0,
        REG_ANGLE_THR = 3'd1,
        REG_DETECT_EN = 3'd2,
        REG_CAL_VALID = 3'd3,
        REG_CAL_X     = 3'd4,
        REG_CAL_Y     = 3'd5,
        REG_CAL_Z     = 3'd6
    } reg_idx_t;

    localparam logic [6:0] COLL_QUIET_MAX = 7'd125;
    localparam logic [6:0] ROLL_COUNT_MAX = 7'd100;
    localparam logic [2:0] FAIL_LIMIT     = 3'd5;

    // milli-g per 0.1 g step
    localparam logic [6:0]  ACCEL_SCALE = 7'd100;
    // floor(a * 1000 / 90) == (a * ANGLE_RECIP) >> 16 for any 8-bit a
    localparam logic [19:0] ANGLE_RECIP = 20'd728178;

    typedef struct packed {
        logic    read_ok;
        sample_t z;
        sample_t y;
        sample_t x;
    } sample_item_t;

    typedef struct packed {
        logic [1:0] change_count;
        logic       rollover_active;
        logic       collision_active;
        logic       sensor_ok;
    } status_t;

    function automatic logic [SAMPLE_W-1:0] absdiff(input sample_t a, input sample_t b);
        logic signed [SAMPLE_W:0] d;
        logic signed [SAMPLE_W:0] m;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        m = d[SAMPLE_W] ? -d : d;
        return m[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/collision_rollover_detector.sv
// ----------------------------------------------------------------------------
// collision_rollover_detector
// per-sample sensor validity, collision and rollover status tracking
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_        in         tdata: x, y, z (16 b signed each); tuser: read_ok
//  m_        out        tdata: sensor_ok, collision, rollover, change_count
//  apb       in/out     7 registers at byte address 4*i, write and read back
//
//  one sample per clock if not stalled; input register, status logic, result register
//  m_tvalid rises once the sample has passed from the input into the result register
//  reset is synchronous on aresetn low; it clears all but the sample and result data
//  a stall on m_tready holds the result and the input register keeps one more sample
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module collision_rollover_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // x, y, z
    input  logic                        s_tuser,   // read_ok
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // sensor_ok, collision, rollover,
                                                   // change_count[1:0], zero pad
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crd_pkg::ADDR_W-1:0]  paddr,
    input  logic [crd_pkg::DATA_W-1:0]  pwdata,
    output logic [crd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import crd_pkg::*;

    // configuration
    logic [7:0]  accel_thr_reg;
    logic [7:0]  angle_thr_reg;
    logic        detect_en_reg;
    logic        cal_valid_reg;
    sample_t     cal_x_reg;
    sample_t     cal_y_reg;
    sample_t     cal_z_reg;
    logic [14:0] cth_reg;
    logic [11:0] rth_reg;
    logic [14:0] cth_next;
    logic [27:0] rth_prod;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    logic        en_on_wr;

    // stream pipeline
    logic         in_valid_reg;
    sample_item_t in_item_reg;
    logic         out_valid_reg;
    status_t      out_status_reg;
    logic         out_free;
    logic         step_en;

    // detector state
    sample_t     prev_x_reg, prev_x_next;
    sample_t     prev_y_reg, prev_y_next;
    sample_t     prev_z_reg, prev_z_next;
    logic        valid_reg, valid_next;
    logic        coll_reg, coll_next;
    logic        roll_reg, roll_next;
    logic [6:0]  quiet_reg, quiet_next;
    logic [6:0]  rcnt_reg, rcnt_next;
    logic [2:0]  fail_reg, fail_next;
    logic        halted_reg, halted_next;

    logic        det_on;
    logic        prev_nz;
    sample_t     ref_x;
    sample_t     ref_y;
    logic        coll_hit;
    logic        roll_hit;
    logic [6:0]  quiet_inc;
    logic [6:0]  rcnt_inc;
    logic [2:0]  fail_inc;
    logic [1:0]  changes;
    status_t     status_next;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign en_on_wr = pwdata[0] & (|accel_thr_reg) & (|angle_thr_reg);

    assign cth_next = {7'b0, accel_thr_reg} * {8'b0, ACCEL_SCALE};
    assign rth_prod = {20'b0, angle_thr_reg} * {8'b0, ANGLE_RECIP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_thr_reg <= '0;
            angle_thr_reg <= '0;
            detect_en_reg <= 1'b0;
            cal_valid_reg <= 1'b0;
            cal_x_reg     <= '0;
            cal_y_reg     <= '0;
            cal_z_reg     <= '0;
            cth_reg       <= '0;
            rth_reg       <= '0;
        end else begin
            cth_reg <= cth_next;
            rth_reg <= rth_prod[27:16];
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_ACCEL_THR: accel_thr_reg <= pwdata[7:0];
                    REG_ANGLE_THR: angle_thr_reg <= pwdata[7:0];
                    REG_DETECT_EN: detect_en_reg <= pwdata[0];
                    REG_CAL_VALID: cal_valid_reg <= pwdata[0];
                    REG_CAL_X:     cal_x_reg     <= pwdata[SAMPLE_W-1:0];
                    REG_CAL_Y:     cal_y_reg     <= pwdata[SAMPLE_W-1:0];
                    REG_CAL_Z:     cal_z_reg     <= pwdata[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ACCEL_THR: prdata = {24'b0, accel_thr_reg};
            REG_ANGLE_THR: prdata = {24'b0, angle_thr_reg};
            REG_DETECT_EN: prdata = {31'b0, detect_en_reg};
            REG_CAL_VALID: prdata = {31'b0, cal_valid_reg};
            REG_CAL_X:     prdata = {16'b0, cal_x_reg};
            REG_CAL_Y:     prdata = {16'b0, cal_y_reg};
            REG_CAL_Z:     prdata = {16'b0, cal_z_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // stream pipeline
    // ------------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, out_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.read_ok <= s_tuser;
            in_item_reg.x       <= s_tdata[15:0];
            in_item_reg.y       <= s_tdata[31:16];
            in_item_reg.z       <= s_tdata[47:32];
        end
        if (step_en) begin
            out_status_reg <= status_next;
        end
    end

    // ------------------------------------------------------------------------
    // status update for the sample in the input register
    // ------------------------------------------------------------------------
    assign det_on  = detect_en_reg && (|accel_thr_reg) && (|angle_thr_reg);
    assign prev_nz = (|prev_x_reg) || (|prev_y_reg) || (|prev_z_reg);
    assign ref_x   = cal_valid_reg ? cal_x_reg : '0;
    assign ref_y   = cal_valid_reg ? cal_y_reg : '0;

    assign coll_hit = prev_nz &&
        ((absdiff(in_item_reg.x, prev_x_reg) > {1'b0, cth_reg}) ||
         (absdiff(in_item_reg.y, prev_y_reg) > {1'b0, cth_reg}));

    assign roll_hit = prev_nz &&
        ((absdiff(in_item_reg.x, ref_x) > {4'b0, rth_reg}) ||
         (absdiff(in_item_reg.y, ref_y) > {4'b0, rth_reg}) ||
         (cal_valid_reg && (absdiff(in_item_reg.z, cal_z_reg) > {4'b0, rth_reg})));

    assign quiet_inc = quiet_reg + 7'd1;
    assign rcnt_inc  = rcnt_reg + 7'd1;
    assign fail_inc  = fail_reg + 3'd1;

    always_comb begin
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        prev_z_next = prev_z_reg;
        valid_next  = valid_reg;
        coll_next   = coll_reg;
        roll_next   = roll_reg;
        quiet_next  = quiet_reg;
        rcnt_next   = rcnt_reg;
        fail_next   = fail_reg;
        halted_next = halted_reg;
        changes     = 2'd0;

        if (!halted_reg) begin
            if (in_item_reg.read_ok) begin
                if (!valid_reg) begin
                    valid_next = 1'b1;
                    changes    = changes + 2'd1;
                end
                if (det_on) begin
                    if (coll_hit) begin
                        quiet_next = '0;
                        if (!coll_reg) begin
                            coll_next = 1'b1;
                            changes   = changes + 2'd1;
                        end
                    end else if (coll_reg) begin
                        if (quiet_inc > COLL_QUIET_MAX) begin
                            quiet_next = '0;
                            coll_next  = 1'b0;
                            changes    = changes + 2'd1;
                        end else begin
                            quiet_next = quiet_inc;
                        end
                    end

                    if (roll_hit) begin
                        if (!roll_reg) begin
                            if (coll_next) begin
                                if (rcnt_inc > ROLL_COUNT_MAX) begin
                                    rcnt_next = '0;
                                    roll_next = 1'b1;
                                    changes   = changes + 2'd1;
                                end else begin
                                    rcnt_next = rcnt_inc;
                                end
                            end
                        end else begin
                            rcnt_next = '0;
                        end
                    end else if (roll_reg) begin
                        if (rcnt_inc > ROLL_COUNT_MAX) begin
                            rcnt_next = '0;
                            roll_next = 1'b0;
                            changes   = changes + 2'd1;
                        end else begin
                            rcnt_next = rcnt_inc;
                        end
                    end else begin
                        rcnt_next = '0;
                    end

                    prev_x_next = in_item_reg.x;
                    prev_y_next = in_item_reg.y;
                    prev_z_next = in_item_reg.z;
                end
            end else begin
                if (fail_inc >= FAIL_LIMIT) begin
                    fail_next   = '0;
                    valid_next  = 1'b0;
                    halted_next = 1'b1;
                    changes     = changes + 2'd1;
                end else begin
                    fail_next = fail_inc;
                end
            end
        end

        status_next.sensor_ok        = valid_next;
        status_next.collision_active = coll_next;
        status_next.rollover_active  = roll_next;
        status_next.change_count     = changes;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            valid_reg  <= 1'b0;
            coll_reg   <= 1'b0;
            roll_reg   <= 1'b0;
            quiet_reg  <= '0;
            rcnt_reg   <= '0;
            fail_reg   <= '0;
            halted_reg <= 1'b0;
        end else if (cfg_wr && cfg_idx == REG_DETECT_EN) begin
            if (en_on_wr) begin
                halted_reg <= 1'b0;
            end else begin
                coll_reg   <= 1'b0;
                roll_reg   <= 1'b0;
                halted_reg <= 1'b1;
            end
        end else if (step_en) begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            prev_z_reg <= prev_z_next;
            valid_reg  <= valid_next;
            coll_reg   <= coll_next;
            roll_reg   <= roll_next;
            quiet_reg  <= quiet_next;
            rcnt_reg   <= rcnt_next;
            fail_reg   <= fail_next;
            halted_reg <= halted_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_halted_no_change, step_en && halted_reg,
        out_status_reg.change_count == 2'd0, "halted sample reported a status change")
    `ASSERT_IMPL(a_fail_below_limit, 1'b1, fail_reg < FAIL_LIMIT,
        "failure count reached the limit without wrapping")
    `ASSERT_IMPL(a_roll_needs_coll, $rose(roll_reg), coll_reg,
        "rollover set without an active collision")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for collision_rollover_detector
// A short directed sequence covers reset status, extreme samples, the failed-read
// halt and the enable-register rules. Random phases then follow. Crash phases hold
// a sudden tilt long enough to raise and drop rollover. Noise phases use random
// settings and samples. Results are checked against a cycle-free predictor
// of the status logic, or against the status given for a directed sample.
// ----------------------------------------------------------------------------
module testbench;
    import crd_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // x, y, z
    logic        s_tuser = 1'b0;   // read_ok
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // sensor_ok, collision, rollover, change_count[1:0], pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    collision_rollover_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // register copies
    logic [7:0] accel_thr = '0;
    logic [7:0] angle_thr = '0;
    logic       detect_en = 1'b0;
    logic       cal_on = 1'b0;
    int         cal_x_mg = 0;
    int         cal_y_mg = 0;
    int         cal_z_mg = 0;

    // detector status
    sample_t    last_x = '0;
    sample_t    last_y = '0;
    sample_t    last_z = '0;
    logic       sensor_valid = 1'b0;
    logic       in_collision = 1'b0;
    logic       in_rollover = 1'b0;
    logic [6:0] quiet_run = '0;
    logic [6:0] roll_run = '0;
    logic [2:0] failed_reads = '0;
    logic       frozen = 1'b0;

    status_t status_due[$];

    typedef struct {
        bit           is_reg;
        reg_idx_t     idx;
        logic [31:0]  value;
        sample_item_t item;
        bit           typed;
        status_t      want;
    } plan_row_t;

    plan_row_t plan[$];

    bit calm = 1'b0;
    int ready_hold = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int coll_results = 0;
    int roll_results = 0;
    int change_results = 0;
    int samples_sent = 0;
    int fail_sent = 0;
    int reg_writes = 0;

    function automatic int mag(int a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic bit detect_live();
        return detect_en && accel_thr != 0 && angle_thr != 0;
    endfunction

    function automatic void apply_reg(reg_idx_t idx, logic [31:0] value);
        case (idx)
            REG_ACCEL_THR: accel_thr = value[7:0];
            REG_ANGLE_THR: angle_thr = value[7:0];
            REG_DETECT_EN: begin
                detect_en = value[0];
                if (detect_live()) begin
                    frozen = 1'b0;
                end else begin
                    in_collision = 1'b0;
                    in_rollover = 1'b0;
                    frozen = 1'b1;
                end
            end
            REG_CAL_VALID: cal_on = value[0];
            REG_CAL_X: cal_x_mg = $signed(value[15:0]);
            REG_CAL_Y: cal_y_mg = $signed(value[15:0]);
            REG_CAL_Z: cal_z_mg = $signed(value[15:0]);
            default: ;
        endcase
    endfunction

    function automatic status_t predict_status(sample_item_t it);
        status_t res;
        int x, y, z, px, py, pz, coll_lim, tilt_lim, notes;
        bit jolt, tilt;
        notes = 0;
        if (!frozen) begin
            if (it.read_ok) begin
                x = $signed(it.x);
                y = $signed(it.y);
                z = $signed(it.z);
                if (!sensor_valid) begin
                    sensor_valid = 1'b1;
                    notes++;
                end
                if (detect_live()) begin
                    jolt = 1'b0;
                    tilt = 1'b0;
                    px = $signed(last_x);
                    py = $signed(last_y);
                    pz = $signed(last_z);
                    // an all-zero previous sample never triggers anything
                    if (px != 0 || py != 0 || pz != 0) begin
                        coll_lim = int'(accel_thr) * int'(ACCEL_SCALE);
                        tilt_lim = (int'(angle_thr) * 1000) / 90;
                        jolt = mag(x - px) > coll_lim || mag(y - py) > coll_lim;
                        if (cal_on) begin
                            tilt = mag(x - cal_x_mg) > tilt_lim || mag(y - cal_y_mg) > tilt_lim
                                || mag(z - cal_z_mg) > tilt_lim;
                        end else begin
                            tilt = mag(x) > tilt_lim || mag(y) > tilt_lim;
                        end
                    end
                    if (jolt) begin
                        quiet_run = '0;
                        if (!in_collision) begin
                            in_collision = 1'b1;
                            notes++;
                        end
                    end else if (in_collision) begin
                        quiet_run = quiet_run + 7'd1;
                        if (quiet_run > COLL_QUIET_MAX) begin
                            quiet_run = '0;
                            in_collision = 1'b0;
                            notes++;
                        end
                    end
                    if (tilt) begin
                        if (!in_rollover) begin
                            // tilt only counts while a collision is active
                            if (in_collision) begin
                                roll_run = roll_run + 7'd1;
                                if (roll_run > ROLL_COUNT_MAX) begin
                                    roll_run = '0;
                                    in_rollover = 1'b1;
                                    notes++;
                                end
                            end
                        end else begin
                            roll_run = '0;
                        end
                    end else if (in_rollover) begin
                        roll_run = roll_run + 7'd1;
                        if (roll_run > ROLL_COUNT_MAX) begin
                            roll_run = '0;
                            in_rollover = 1'b0;
                            notes++;
                        end
                    end else begin
                        roll_run = '0;
                    end
                    last_x = it.x;
                    last_y = it.y;
                    last_z = it.z;
                end
            end else begin
                failed_reads = failed_reads + 3'd1;
                if (failed_reads >= FAIL_LIMIT) begin
                    failed_reads = '0;
                    sensor_valid = 1'b0;
                    frozen = 1'b1;
                    notes++;
                end
            end
        end
        res.sensor_ok = sensor_valid;
        res.collision_active = in_collision;
        res.rollover_active = in_rollover;
        res.change_count = notes[1:0];
        return res;
    endfunction

    function automatic status_t status_of(bit ok, bit coll, bit roll, int changes);
        status_t s;
        s.sensor_ok = ok;
        s.collision_active = coll;
        s.rollover_active = roll;
        s.change_count = changes[1:0];
        return s;
    endfunction

    function automatic void plan_reg(reg_idx_t idx, logic [31:0] value);
        plan_row_t row;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.value = value;
        row.item = '0;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_sample(bit ok, int x, int y, int z, bit typed = 1'b0,
                                        status_t want = '0);
        plan_row_t row;
        row.is_reg = 1'b0;
        row.idx = REG_ACCEL_THR;
        row.value = '0;
        row.item.read_ok = ok;
        row.item.x = sample_t'(x);
        row.item.y = sample_t'(y);
        row.item.z = sample_t'(z);
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return 255;
        if (r < 40) return 1;
        return $urandom_range(2, 254);
    endfunction

    function automatic int pick_val();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return -32768;
        if (r < 20) return 32767;
        if (r < 28) return 0;
        if (r < 34) return -1;
        if (r < 60) return int'($urandom_range(0, 6000)) - 3000;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void check_result(logic [7:0] raw);
        status_t got, want;
        got = raw[4:0];
        if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %b at %0t", raw, $time);
        end else begin
            want = status_due.pop_front();
            if (got.sensor_ok !== want.sensor_ok
                || got.collision_active !== want.collision_active
                || got.rollover_active !== want.rollover_active
                || got.change_count !== want.change_count
                || raw[7:5] !== 3'b000) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected ok/coll/roll=%b%b%b changes=%0d",
                             results_seen, want.sensor_ok, want.collision_active,
                             want.rollover_active, want.change_count);
                    $display("    got ok/coll/roll=%b%b%b changes=%0d pad=%b",
                             got.sensor_ok, got.collision_active, got.rollover_active,
                             got.change_count, raw[7:5]);
                end
            end
        end
        results_seen++;
        if (got.collision_active === 1'b1) coll_results++;
        if (got.rollover_active === 1'b1) roll_results++;
        if (got.change_count != 2'd0) change_results++;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_reg(idx, value);
        reg_writes++;
    endtask

    task automatic send_sample(sample_item_t it, bit typed, status_t typed_want);
        status_t pred;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {it.z, it.y, it.x};
        s_tuser <= it.read_ok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_status(it);
        status_due.push_back(typed ? typed_want : pred);
        samples_sent++;
        if (!it.read_ok) fail_sent++;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result side with random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        if (ready_hold != 0) begin
            ready_hold--;
        end else if (calm || $urandom_range(0, 1) == 1) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end else begin
            m_tready <= 1'b0;
            ready_hold = idle_len();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        sample_item_t it;
        int random_goal, accel, angle, cal, bx, by, bz, nz, axis, amt;
        int n_rest, n_tilt, n_back, k, n;
        int d[3];

        // reset status, detection off
        plan_sample(1, 0, 0, 0, 1, status_of(1, 0, 0, 1));
        plan_sample(1, 32767, -32768, -1, 1, status_of(1, 0, 0, 0));
        plan_sample(0, -1, -1, -1, 1, status_of(1, 0, 0, 0));
        // largest thresholds
        plan_reg(REG_ACCEL_THR, 255);
        plan_reg(REG_ANGLE_THR, 255);
        plan_reg(REG_CAL_VALID, 0);
        plan_reg(REG_DETECT_EN, 1);
        plan_sample(1, -32768, 32767, -32768, 1, status_of(1, 0, 0, 0));
        plan_sample(1, 32767, -32768, 32767, 1, status_of(1, 1, 0, 1));
        plan_sample(1, 0, 0, 0);
        // fifth failed read halts and drops the valid bit
        plan_sample(0, 0, 0, 0);
        plan_sample(0, 32767, 32767, 32767);
        plan_sample(0, -32768, -32768, -32768);
        plan_sample(0, 0, 0, 0, 1, status_of(0, 1, 0, 1));
        plan_sample(1, 100, 100, 100, 1, status_of(0, 1, 0, 0));
        // calibration extremes, enable write resumes
        plan_reg(REG_CAL_X, 32'hFFFF_8000);
        plan_reg(REG_CAL_Y, 32767);
        plan_reg(REG_CAL_Z, 32'h0000_8000);
        plan_reg(REG_CAL_VALID, 1);
        plan_reg(REG_DETECT_EN, 1);
        plan_sample(1, -32768, 32767, -32768);
        plan_sample(1, 0, 0, 0);
        // zero threshold turns detection off without a halt
        plan_reg(REG_ACCEL_THR, 0);
        plan_sample(1, 5, -5, 5);
        // enable off clears the event flags and halts
        plan_reg(REG_DETECT_EN, 0);
        plan_sample(1, 1, 1, 1, 1, status_of(1, 0, 0, 0));
        plan_reg(REG_ANGLE_THR, 0);
        plan_reg(REG_ACCEL_THR, 255);
        plan_reg(REG_DETECT_EN, 1);
        plan_sample(0, 7, 7, 7);
        plan_reg(REG_ANGLE_THR, 1);
        plan_reg(REG_DETECT_EN, 1);
        plan_sample(1, 100, 0, 0);
        plan_sample(1, -32768, 32767, 0);
        plan_sample(1, -32768, 32767, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_reg)
                write_reg(plan[i].idx, plan[i].value);
            else
                send_sample(plan[i].item, plan[i].typed, plan[i].want);
        end

        random_goal = 950;
        while (samples_sent < random_goal) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0) begin
                // crash: rest, sudden tilt held long enough to roll, then rest again
                accel = $urandom_range(1, 20);
                angle = $urandom_range(1, 60);
                cal = $urandom_range(0, 1);
                bx = cal ? int'($urandom_range(0, 16000)) - 8000 : 0;
                by = cal ? int'($urandom_range(0, 16000)) - 8000 : 0;
                bz = cal ? int'($urandom_range(0, 16000)) - 8000 : 1000;
                write_reg(REG_ACCEL_THR, accel);
                write_reg(REG_ANGLE_THR, angle);
                write_reg(REG_CAL_VALID, cal);
                write_reg(REG_CAL_X, bx);
                write_reg(REG_CAL_Y, by);
                write_reg(REG_CAL_Z, bz);
                write_reg(REG_DETECT_EN, 1);
                // jitter stays below both thresholds
                nz = (angle * 1000 / 90) / 2;
                if (nz > accel * 50) nz = accel * 50;
                axis = $urandom_range(0, cal ? 2 : 1);
                amt = $urandom_range(2500, 9000);
                if ($urandom_range(0, 1) == 1) amt = -amt;
                n_rest = $urandom_range(3, 10);
                n_tilt = $urandom_range(105, 200);
                n_back = $urandom_range(105, 160);
                for (k = 0; k < n_rest + n_tilt + n_back && samples_sent < random_goal;
                     k++) begin
                    d[0] = bx + int'($urandom_range(0, 2 * nz)) - nz;
                    d[1] = by + int'($urandom_range(0, 2 * nz)) - nz;
                    d[2] = bz + int'($urandom_range(0, 2 * nz)) - nz;
                    if (k >= n_rest && k < n_rest + n_tilt) begin
                        d[axis] += amt;
                        if ($urandom_range(0, 49) == 0) d[0] += accel * 100 + 500;
                    end
                    it.read_ok = ($urandom_range(0, 199) != 0);
                    it.x = sample_t'(d[0]);
                    it.y = sample_t'(d[1]);
                    it.z = sample_t'(d[2]);
                    send_sample(it, 1'b0, '0);
                end
            end else begin
                accel = pick_level();
                angle = pick_level();
                write_reg(REG_ACCEL_THR, accel);
                write_reg(REG_ANGLE_THR, angle);
                write_reg(REG_CAL_VALID, $urandom_range(0, 1));
                write_reg(REG_CAL_X, pick_val());
                write_reg(REG_CAL_Y, pick_val());
                write_reg(REG_CAL_Z, pick_val());
                if ($urandom_range(0, 6) != 0)
                    write_reg(REG_DETECT_EN, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
                n = $urandom_range(15, 60);
                for (k = 0; k < n && samples_sent < random_goal; k++) begin
                    it.read_ok = ($urandom_range(0, 99) >= 12);
                    it.x = sample_t'(pick_val());
                    it.y = sample_t'(pick_val());
                    it.z = sample_t'(pick_val());
                    send_sample(it, 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d samples (%0d failed reads) and %0d register writes",
                 samples_sent, fail_sent, reg_writes);
        $display("%0d results: %0d in collision, %0d in rollover, %0d with status changes",
                 results_seen, coll_results, roll_results, change_results);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
